/* hw/rtl/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the opcode field
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RD8    = 3'd1;
    localparam logic [2:0] OP_WR8    = 3'd2;
    localparam logic [2:0] OP_RD16BE = 3'd3;
    localparam logic [2:0] OP_RD16LE = 3'd4;
    localparam logic [2:0] OP_WR16BE = 3'd5;
    localparam logic [2:0] OP_WR16LE = 3'd6;

    localparam logic [15:0] HALF_BIT_RESET = 16'd5;

    // Byte slots within one transaction
    localparam logic [2:0] IDX_ADDR_WR = 3'd0;
    localparam logic [2:0] IDX_REG     = 3'd1;
    localparam logic [2:0] IDX_SECOND  = 3'd2;
    localparam logic [2:0] IDX_THIRD   = 3'd3;
    localparam logic [2:0] IDX_LAST16  = 3'd4;

    localparam logic [3:0] BIT_ACK = 4'd8;
    localparam logic [3:0] BIT_LAST_DATA = 4'd7;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_START = 4'd1,
        PH_BLOW  = 4'd2,
        PH_BHIGH = 4'd3,
        PH_RSA   = 4'd4,
        PH_RSB   = 4'd5,
        PH_MIDA  = 4'd6,
        PH_MIDB  = 4'd7,
        PH_MIDC  = 4'd8,
        PH_ENDA  = 4'd9,
        PH_ENDB  = 4'd10,
        PH_ENDC  = 4'd11,
        PH_ERRA  = 4'd12,
        PH_ERRB  = 4'd13,
        PH_ERRC  = 4'd14
    } phase_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  slave_addr;
        logic [7:0]  reg_addr;
        logic [15:0] write_value;
        logic        stop_between;
        logic        sda_in;
    } cmd_t;

    typedef struct packed {
        logic        scl_drive_low;
        logic        sda_drive_low;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic [15:0] read_data;
        logic        rejected;
    } res_t;

    function automatic logic is_read(input logic [2:0] cmd);
        return (cmd == OP_RD8) || (cmd == OP_RD16BE) || (cmd == OP_RD16LE);
    endfunction

    function automatic logic [2:0] last_index(input logic [2:0] cmd);
        logic [2:0] idx;
        case (cmd)
            OP_RD8:    idx = IDX_THIRD;
            OP_WR8:    idx = IDX_SECOND;
            OP_RD16BE: idx = IDX_LAST16;
            OP_RD16LE: idx = IDX_LAST16;
            default:   idx = IDX_THIRD;
        endcase
        return idx;
    endfunction

    function automatic logic [7:0] load_byte(
        input logic [2:0]  cmd,
        input logic [6:0]  slave,
        input logic [7:0]  regn,
        input logic [15:0] value,
        input logic [2:0]  idx
    );
        logic [7:0] b;
        b = 8'h00;
        if (idx == IDX_ADDR_WR)
        begin
            b = {slave, 1'b0};
        end
        else if (idx == IDX_REG)
        begin
            b = regn;
        end
        else if (idx == IDX_SECOND)
        begin
            if (is_read(cmd))
                b = {slave, 1'b1};
            else
                b = (cmd == OP_WR16BE) ? value[15:8] : value[7:0];
        end
        else if (idx == IDX_THIRD && !is_read(cmd))
        begin
            b = (cmd == OP_WR16BE) ? value[7:0] : value[15:8];
        end
        return b;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2cm_core.sv */
`default_nettype none

module i2cm_core
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire cmd_t        item,
    input  wire logic [15:0] half_bit_ticks,
    output res_t             result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] data_acc_reg, data_acc_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [6:0]  slave_reg, slave_next;
    logic [7:0]  regn_reg, regn_next;
    logic [15:0] value_reg, value_next;
    logic        stop_reg, stop_next;

    logic        done, err, rej;
    logic [15:0] hb;
    logic [16:0] tick_inc;
    logic        rx_now;
    logic        rx_after;
    logic [2:0]  idx_inc;
    logic [7:0]  shifted;

    // Hold time of each bus level; zero acts as one
    assign hb       = (half_bit_ticks == 16'd0) ? 16'd1 : half_bit_ticks;
    assign tick_inc = {1'b0, tick_count_reg} + 17'd1;
    assign rx_now   = is_read(cmd_reg) && (byte_index_reg >= IDX_THIRD);
    assign idx_inc  = 3'(byte_index_reg + 3'd1);
    assign rx_after = is_read(cmd_reg) && (idx_inc >= IDX_THIRD);
    assign shifted  = {shift_reg[6:0], rx_now ? item.sda_in : 1'b0};

    // Next state: latch commands, count ticks, advance phases
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        shift_next      = shift_reg;
        tick_count_next = tick_count_reg;
        data_acc_next   = data_acc_reg;
        cmd_next        = cmd_reg;
        slave_next      = slave_reg;
        regn_next       = regn_reg;
        value_next      = value_reg;
        stop_next       = stop_reg;
        done            = 1'b0;
        err             = 1'b0;
        rej             = 1'b0;

        if (step)
        begin
            if (item.opcode == OP_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (tick_inc >= {1'b0, hb})
                    begin
                        tick_count_next = 16'd0;
                        case (phase_reg)
                            PH_START:
                            begin
                                phase_next     = PH_BLOW;
                                bit_count_next = 4'd0;
                            end
                            PH_BLOW: phase_next = PH_BHIGH;
                            PH_BHIGH:
                            begin
                                if (bit_count_reg < BIT_ACK)
                                begin
                                    shift_next = shifted;
                                    if (rx_now && bit_count_reg == BIT_LAST_DATA)
                                    begin
                                        if (byte_index_reg == IDX_THIRD)
                                            data_acc_next = (cmd_reg == OP_RD16BE)
                                                ? {shifted, 8'h00} : {8'h00, shifted};
                                        else if (cmd_reg == OP_RD16BE)
                                            data_acc_next = data_acc_reg | {8'h00, shifted};
                                        else
                                            data_acc_next = data_acc_reg | {shifted, 8'h00};
                                    end
                                    bit_count_next = 4'(bit_count_reg + 4'd1);
                                    phase_next     = PH_BLOW;
                                end
                                else if (!rx_now && item.sda_in)
                                begin
                                    phase_next = PH_ERRA;
                                end
                                else if (byte_index_reg == last_index(cmd_reg))
                                begin
                                    phase_next = PH_ENDA;
                                end
                                else if (is_read(cmd_reg) && byte_index_reg == IDX_REG)
                                begin
                                    byte_index_next = IDX_SECOND;
                                    shift_next = load_byte(cmd_reg, slave_reg, regn_reg,
                                                           value_reg, IDX_SECOND);
                                    phase_next = stop_reg ? PH_MIDA : PH_RSA;
                                end
                                else
                                begin
                                    byte_index_next = idx_inc;
                                    shift_next = rx_after ? 8'h00
                                        : load_byte(cmd_reg, slave_reg, regn_reg,
                                                    value_reg, idx_inc);
                                    bit_count_next = 4'd0;
                                    phase_next     = PH_BLOW;
                                end
                            end
                            PH_RSA:  phase_next = PH_RSB;
                            PH_RSB:  phase_next = PH_START;
                            PH_MIDA: phase_next = PH_MIDB;
                            PH_MIDB: phase_next = PH_MIDC;
                            PH_MIDC: phase_next = PH_START;
                            PH_ENDA: phase_next = PH_ENDB;
                            PH_ENDB: phase_next = PH_ENDC;
                            PH_ENDC:
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            PH_ERRA: phase_next = PH_ERRB;
                            PH_ERRB: phase_next = PH_ERRC;
                            PH_ERRC:
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                                err        = 1'b1;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                    else
                    begin
                        tick_count_next = tick_inc[15:0];
                    end
                end
            end
            else if (item.opcode <= OP_WR16LE)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    cmd_next        = item.opcode;
                    slave_next      = item.slave_addr;
                    regn_next       = item.reg_addr;
                    value_next      = item.write_value;
                    stop_next       = item.stop_between;
                    data_acc_next   = 16'h0000;
                    byte_index_next = IDX_ADDR_WR;
                    bit_count_next  = 4'd0;
                    tick_count_next = 16'd0;
                    shift_next      = load_byte(item.opcode, item.slave_addr, item.reg_addr,
                                                item.write_value, IDX_ADDR_WR);
                    phase_next      = PH_START;
                end
            end
        end
    end

    // Outputs: bus drives and status after this request
    always_comb
    begin
        logic rx_n;
        logic data_low;
        rx_n = is_read(cmd_next) && (byte_index_next >= IDX_THIRD);
        if (rx_n)
            data_low = (bit_count_next >= BIT_ACK) ? (byte_index_next != last_index(cmd_next))
                                                   : 1'b0;
        else
            data_low = (bit_count_next >= BIT_ACK) ? 1'b0 : !shift_next[7];

        case (phase_next)
            PH_START:
            begin
                result.scl_drive_low = 1'b0;
                result.sda_drive_low = 1'b1;
            end
            PH_BLOW:
            begin
                result.scl_drive_low = 1'b1;
                result.sda_drive_low = data_low;
            end
            PH_BHIGH:
            begin
                result.scl_drive_low = 1'b0;
                result.sda_drive_low = data_low;
            end
            PH_RSA:
            begin
                result.scl_drive_low = 1'b1;
                result.sda_drive_low = 1'b0;
            end
            PH_MIDA, PH_ENDA, PH_ERRA:
            begin
                result.scl_drive_low = 1'b1;
                result.sda_drive_low = 1'b1;
            end
            PH_MIDB, PH_ENDB, PH_ERRB:
            begin
                result.scl_drive_low = 1'b0;
                result.sda_drive_low = 1'b1;
            end
            default:
            begin
                result.scl_drive_low = 1'b0;
                result.sda_drive_low = 1'b0;
            end
        endcase

        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done;
        result.nack_error = err;
        result.read_data  = (done && !err && is_read(cmd_next)) ? data_acc_next : 16'h0000;
        result.rejected   = rej;
    end

    // Hold transaction state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            byte_index_reg <= 3'd0;
            shift_reg      <= 8'h00;
            tick_count_reg <= 16'd0;
            data_acc_reg   <= 16'h0000;
            cmd_reg        <= 3'd0;
            slave_reg      <= 7'd0;
            regn_reg       <= 8'h00;
            value_reg      <= 16'h0000;
            stop_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_index_reg <= byte_index_next;
            shift_reg      <= shift_next;
            tick_count_reg <= tick_count_next;
            data_acc_reg   <= data_acc_next;
            cmd_reg        <= cmd_next;
            slave_reg      <= slave_next;
            regn_reg       <= regn_next;
            value_reg      <= value_next;
            stop_reg       <= stop_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/i2c_master_register_transactions.sv */
// Flow: an accepted request is held in the input register, and its response is
// written to the result register once that register is empty or being taken.
// Throughput: one request per cycle while res_stall is low; the controller state
// updates once per request in a single pass between the input register and the
// result register. Reset: bus released, controller idle, all counters cleared,
// half_bit_ticks = 5, no request or result pending.
`default_nettype none

module i2c_master_register_transactions
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_t             res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    cmd_t        in_data_reg;
    logic        res_valid_reg, res_valid_next;
    res_t        res_data_reg;
    logic [15:0] half_bit_reg;
    logic        adv;
    logic        accept;
    res_t        core_res;

    // Process the held request when the result register can take it
    assign adv       = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !adv;
    assign accept    = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

    i2cm_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (adv),
        .item           (in_data_reg),
        .half_bit_ticks (half_bit_reg),
        .result         (core_res)
    );

    // Advance valid flags of both stages
    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (adv)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            half_bit_reg  <= HALF_BIT_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
                half_bit_reg <= cfg_data;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        if (accept)
            in_data_reg <= cmd;
        if (adv)
            res_data_reg <= core_res;
    end

endmodule

`default_nettype wire

/* bench/i2c_master_register_transactions_tb.sv */
`timescale 1ns / 100ps

module i2c_master_register_transactions_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int NO_NACK = 8;
    localparam int FILL_LOW = 0;
    localparam int FILL_HIGH = 1;
    localparam int FILL_RANDOM = 2;
    localparam int RANDOM_REQUESTS = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd_item = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    // Bus controller image kept in step with the block
    phase_t      m_phase;
    logic [3:0]  m_bit;
    logic [2:0]  m_byte;
    logic [7:0]  m_shift;
    logic [15:0] m_ticks;
    logic [15:0] m_acc;
    logic [2:0]  m_op;
    logic [6:0]  m_slave;
    logic [7:0]  m_reg;
    logic [15:0] m_value;
    logic        m_stop;
    logic [15:0] m_half;

    res_t pending_responses[$];
    int   requests = 0;
    int   failures = 0;
    int   transfers_done = 0;
    int   nacks_seen = 0;
    int   rejects_seen = 0;
    int   half_bit_writes = 0;
    int   cycles = 0;
    bit   calm = 1'b0;

    i2c_master_register_transactions uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic logic reading();
        return (m_op == OP_RD8) || (m_op == OP_RD16BE) || (m_op == OP_RD16LE);
    endfunction

    function automatic logic [2:0] final_slot();
        case (m_op)
            OP_WR8:               return IDX_SECOND;
            OP_RD16BE, OP_RD16LE: return IDX_LAST16;
            default:              return IDX_THIRD;
        endcase
    endfunction

    function automatic logic receiving_now();
        return reading() && (m_byte >= IDX_THIRD);
    endfunction

    function automatic logic [7:0] outgoing_byte(input logic [2:0] slot);
        case (slot)
            IDX_ADDR_WR: return {m_slave, 1'b0};
            IDX_REG:     return m_reg;
            IDX_SECOND:
            begin
                if (reading())
                    return {m_slave, 1'b1};
                return (m_op == OP_WR16BE) ? m_value[15:8] : m_value[7:0];
            end
            IDX_THIRD:
            begin
                if (reading())
                    return 8'h00;
                return (m_op == OP_WR16BE) ? m_value[7:0] : m_value[15:8];
            end
            default:     return 8'h00;
        endcase
    endfunction

    // Pull SDA low for a zero data bit, or for our ACK of a non-final read byte
    function automatic logic sda_pull();
        if (receiving_now())
            return (m_bit >= BIT_ACK) && (m_byte != final_slot());
        if (m_bit >= BIT_ACK)
            return 1'b0;
        return ~m_shift[7];
    endfunction

    function automatic void fold_read_byte(input logic [7:0] v);
        if (m_byte == IDX_THIRD)
            m_acc = (m_op == OP_RD16BE) ? {v, 8'h00} : {8'h00, v};
        else if (m_op == OP_RD16BE)
            m_acc = m_acc | {8'h00, v};
        else
            m_acc = m_acc | {v, 8'h00};
    endfunction

    // Move to the next bus phase when a half-bit hold runs out
    function automatic void end_hold(input logic sda, output logic done, output logic err);
        logic rx;
        done = 1'b0;
        err = 1'b0;
        case (m_phase)
            PH_START:
            begin
                m_phase = PH_BLOW;
                m_bit = 4'd0;
            end
            PH_BLOW: m_phase = PH_BHIGH;
            PH_BHIGH:
            begin
                if (m_bit < BIT_ACK)
                begin
                    rx = receiving_now();
                    m_shift = {m_shift[6:0], rx ? sda : 1'b0};
                    if (rx && m_bit == BIT_LAST_DATA)
                        fold_read_byte(m_shift);
                    m_bit = m_bit + 4'd1;
                    m_phase = PH_BLOW;
                end
                else if (!receiving_now() && sda)
                    m_phase = PH_ERRA;
                else if (m_byte == final_slot())
                    m_phase = PH_ENDA;
                else if (reading() && m_byte == IDX_REG)
                begin
                    m_byte = IDX_SECOND;
                    m_shift = outgoing_byte(IDX_SECOND);
                    m_phase = m_stop ? PH_MIDA : PH_RSA;
                end
                else
                begin
                    m_byte = m_byte + 3'd1;
                    m_shift = receiving_now() ? 8'h00 : outgoing_byte(m_byte);
                    m_bit = 4'd0;
                    m_phase = PH_BLOW;
                end
            end
            PH_RSA:  m_phase = PH_RSB;
            PH_RSB:  m_phase = PH_START;
            PH_MIDA: m_phase = PH_MIDB;
            PH_MIDB: m_phase = PH_MIDC;
            PH_MIDC: m_phase = PH_START;
            PH_ENDA: m_phase = PH_ENDB;
            PH_ENDB: m_phase = PH_ENDC;
            PH_ENDC:
            begin
                m_phase = PH_IDLE;
                done = 1'b1;
            end
            PH_ERRA: m_phase = PH_ERRB;
            PH_ERRB: m_phase = PH_ERRC;
            PH_ERRC:
            begin
                m_phase = PH_IDLE;
                done = 1'b1;
                err = 1'b1;
            end
            default: m_phase = PH_IDLE;
        endcase
    endfunction

    function automatic res_t predict_response(input cmd_t c);
        res_t        r;
        logic        done;
        logic        err;
        logic        rej;
        logic [16:0] hold;
        done = 1'b0;
        err = 1'b0;
        rej = 1'b0;
        if (c.opcode == OP_TICK)
        begin
            if (m_phase != PH_IDLE)
            begin
                hold = (m_half == 16'd0) ? 17'd1 : {1'b0, m_half};
                if ({1'b0, m_ticks} + 17'd1 >= hold)
                begin
                    m_ticks = 16'd0;
                    end_hold(c.sda_in, done, err);
                end
                else
                    m_ticks = m_ticks + 16'd1;
            end
        end
        else if (c.opcode != OP_UNUSED)
        begin
            if (m_phase != PH_IDLE)
                rej = 1'b1;
            else
            begin
                m_op = c.opcode;
                m_slave = c.slave_addr;
                m_reg = c.reg_addr;
                m_value = c.write_value;
                m_stop = c.stop_between;
                m_acc = 16'd0;
                m_byte = IDX_ADDR_WR;
                m_bit = 4'd0;
                m_ticks = 16'd0;
                m_shift = outgoing_byte(IDX_ADDR_WR);
                m_phase = PH_START;
            end
        end

        case (m_phase)
            PH_START:                  {r.scl_drive_low, r.sda_drive_low} = 2'b01;
            PH_BLOW:                   {r.scl_drive_low, r.sda_drive_low} = {1'b1, sda_pull()};
            PH_BHIGH:                  {r.scl_drive_low, r.sda_drive_low} = {1'b0, sda_pull()};
            PH_RSA:                    {r.scl_drive_low, r.sda_drive_low} = 2'b10;
            PH_MIDA, PH_ENDA, PH_ERRA: {r.scl_drive_low, r.sda_drive_low} = 2'b11;
            PH_MIDB, PH_ENDB, PH_ERRB: {r.scl_drive_low, r.sda_drive_low} = 2'b01;
            default:                   {r.scl_drive_low, r.sda_drive_low} = 2'b00;
        endcase
        r.busy_res = (m_phase != PH_IDLE);
        r.done_res = done;
        r.nack_error = err;
        r.read_data = (done && !err && reading()) ? m_acc : 16'd0;
        r.rejected = rej;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly no gap, some short ones, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cmd_t random_item(input logic [2:0] op);
        cmd_t c;
        c.opcode = op;
        c.slave_addr = 7'($urandom_range(0, 127));
        c.reg_addr = 8'($urandom_range(0, 255));
        c.write_value = 16'($urandom_range(0, 65535));
        c.stop_between = 1'($urandom_range(0, 1));
        c.sda_in = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Slave side of SDA: ACK address and write bytes unless told to NACK
    function automatic logic slave_sda(input int nack_at, input int nack_pct, input int fill);
        if (m_phase == PH_BHIGH && m_bit == BIT_ACK && !receiving_now())
            return (int'(m_byte) == nack_at) || ($urandom_range(0, 99) < nack_pct);
        if (fill == FILL_LOW)
            return 1'b0;
        if (fill == FILL_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one request, hold it until taken, then record its expected response
    task automatic send_item(input cmd_t c);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= c;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        pending_responses.push_back(predict_response(c));
        requests++;
    endtask

    // Drop valid and wait for every outstanding response
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_half_bit(input logic [15:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        m_half = v;
        half_bit_writes++;
    endtask

    // Tick the bus until the current transfer ends, mixing in stray requests
    task automatic finish_transaction(input int nack_at, input int nack_pct,
                                      input int fill, input int noise_pct);
        cmd_t c;
        while (m_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                c = random_item(3'($urandom_range(OP_RD8, OP_UNUSED)));
            else
            begin
                c = random_item(OP_TICK);
                c.sda_in = slave_sda(nack_at, nack_pct, fill);
            end
            send_item(c);
        end
    endtask

    task automatic run_transaction(input logic [2:0] op, input logic [6:0] slave,
                                   input logic [7:0] regn, input logic [15:0] value,
                                   input logic stop, input int nack_at, input int nack_pct,
                                   input int fill, input int noise_pct);
        cmd_t c;
        c = random_item(op);
        c.slave_addr = slave;
        c.reg_addr = regn;
        c.write_value = value;
        c.stop_between = stop;
        send_item(c);
        finish_transaction(nack_at, nack_pct, fill, noise_pct);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_each_command();
        write_half_bit(16'd1);
        run_transaction(OP_RD8,    7'h00, 8'h00, 16'h0000, 1'b0, NO_NACK, 0, FILL_LOW, 0);
        run_transaction(OP_WR8,    7'h7f, 8'hff, 16'hffff, 1'b1, NO_NACK, 0, FILL_RANDOM, 0);
        run_transaction(OP_RD16BE, 7'h55, 8'h0f, 16'h0000, 1'b1, NO_NACK, 0, FILL_HIGH, 0);
        run_transaction(OP_RD16LE, 7'h2a, 8'hf0, 16'hffff, 1'b0, NO_NACK, 0, FILL_RANDOM, 0);
        run_transaction(OP_WR16BE, 7'h7f, 8'h00, 16'h12a5, 1'b0, NO_NACK, 0, FILL_RANDOM, 0);
        run_transaction(OP_WR16LE, 7'h00, 8'hff, 16'hffff, 1'b1, NO_NACK, 0, FILL_RANDOM, 0);
    endtask

    task automatic test_slave_nack();
        run_transaction(OP_WR8,    7'h11, 8'h22, 16'h0033, 1'b0, int'(IDX_ADDR_WR), 0,
                        FILL_RANDOM, 0);
        run_transaction(OP_RD16BE, 7'h44, 8'h55, 16'h0000, 1'b0, int'(IDX_REG), 0,
                        FILL_RANDOM, 0);
        run_transaction(OP_RD8,    7'h66, 8'h77, 16'h0000, 1'b1, int'(IDX_SECOND), 0,
                        FILL_RANDOM, 0);
        run_transaction(OP_WR16LE, 7'h08, 8'h99, 16'hbeef, 1'b0, int'(IDX_THIRD), 0,
                        FILL_RANDOM, 0);
    endtask

    task automatic test_busy_and_unused();
        send_item(random_item(OP_TICK));
        send_item(random_item(OP_UNUSED));
        send_item(random_item(OP_WR8));
        send_item(random_item(OP_RD16BE));
        send_item(random_item(OP_UNUSED));
        finish_transaction(NO_NACK, 0, FILL_RANDOM, 20);
    endtask

    task automatic test_half_bit_extremes();
        write_half_bit(16'hffff);
        send_item(random_item(OP_RD8));
        repeat (40) send_item(random_item(OP_TICK));
        // shorten the hold below the ticks already counted
        write_half_bit(16'd2);
        finish_transaction(NO_NACK, 0, FILL_RANDOM, 0);
        write_half_bit(16'd0);
        run_transaction(OP_WR8, 7'h3c, 8'hc3, 16'h5aa5, 1'b0, NO_NACK, 0, FILL_RANDOM, 0);
        write_half_bit(16'd3);
        run_transaction(OP_RD16BE, 7'h7e, 8'h81, 16'h0000, 1'b0, NO_NACK, 0, FILL_RANDOM, 0);
    endtask

    task automatic test_random_traffic();
        int          stop_at;
        logic [15:0] hb;
        stop_at = requests + RANDOM_REQUESTS;
        while (requests < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       hb = 16'd0;
                    1, 2:    hb = 16'($urandom_range(2, 3));
                    default: hb = 16'd1;
                endcase
                write_half_bit(hb);
            end
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 6) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(random_item($urandom_range(0, 1) ? OP_TICK : OP_UNUSED));
            run_transaction(3'($urandom_range(OP_RD8, OP_WR16LE)), 7'($urandom_range(0, 127)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), NO_NACK, 4, FILL_RANDOM, 4);
        end
        calm = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Response stall, checking, watchdog
    // ---------------------------------------------------------------

    initial
    begin : stall_responses
        int len;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            len = gap_len();
            res_stall <= (len != 0);
            if (len == 0)
                len = $urandom_range(1, 12);
            repeat (len) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each taken response with the oldest prediction
    always @(posedge clk)
    begin : check_responses
        res_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response with nothing outstanding: %h", res_item);
                failures++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("scl_drive_low", 16'(want.scl_drive_low),
                            16'(res_item.scl_drive_low));
                check_field("sda_drive_low", 16'(want.sda_drive_low),
                            16'(res_item.sda_drive_low));
                check_field("busy_res", 16'(want.busy_res), 16'(res_item.busy_res));
                check_field("done_res", 16'(want.done_res), 16'(res_item.done_res));
                check_field("nack_error", 16'(want.nack_error), 16'(res_item.nack_error));
                check_field("read_data", want.read_data, res_item.read_data);
                check_field("rejected", 16'(want.rejected), 16'(res_item.rejected));
                transfers_done += int'(want.done_res);
                nacks_seen += int'(want.nack_error);
                rejects_seen += int'(want.rejected);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycles, pending_responses.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        m_phase = PH_IDLE;
        m_bit = 4'd0;
        m_byte = 3'd0;
        m_shift = 8'd0;
        m_ticks = 16'd0;
        m_acc = 16'd0;
        m_op = 3'd0;
        m_slave = 7'd0;
        m_reg = 8'd0;
        m_value = 16'd0;
        m_stop = 1'b0;
        m_half = HALF_BIT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_command();
        test_slave_nack();
        test_busy_and_unused();
        test_half_bit_extremes();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d requests: %0d transfers ended, %0d on a slave NACK, %0d rejected",
                 requests, transfers_done, nacks_seen, rejects_seen);
        $display("Half-bit period rewritten %0d times, including 0, 1 and 65535",
                 half_bit_writes);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
